// ===== rtl/core/tpi_pkg.sv =====
// ----------------------------------------------------------------------------
// tpi_pkg
// shared widths, word types and column mapping for the three-plane solver
// ----------------------------------------------------------------------------
package tpi_pkg;

	localparam int CW   = 32;           // coordinate width
	localparam int FB   = 16;           // fractional bits
	localparam int PW   = 2 * CW;       // 2x2 product width
	localparam int MW   = PW + 1;       // minor width
	localparam int LOW  = CW;           // low slice of a minor, unsigned
	localparam int HIW  = MW - LOW;     // high slice of a minor, signed
	localparam int PPW  = CW + HIW;     // partial product width
	localparam int TW   = CW + MW;      // cofactor term width
	localparam int DW   = TW + 2;       // determinant width
	localparam int NW   = DW + FB;      // scaled numerator width
	localparam int QW   = CW + 1;       // quotient bits kept
	localparam int HW   = NW - QW;      // numerator bits above the quotient
	localparam int NMAT = 4;            // det, then x, y, z numerators

	typedef struct packed {
		logic signed [CW-1:0] first_normal_x;
		logic signed [CW-1:0] first_normal_y;
		logic signed [CW-1:0] first_normal_z;
		logic signed [CW-1:0] first_offset;
		logic signed [CW-1:0] second_normal_x;
		logic signed [CW-1:0] second_normal_y;
		logic signed [CW-1:0] second_normal_z;
		logic signed [CW-1:0] second_offset;
		logic signed [CW-1:0] third_normal_x;
		logic signed [CW-1:0] third_normal_y;
		logic signed [CW-1:0] third_normal_z;
		logic signed [CW-1:0] third_offset;
	} plane_word_t;

	typedef struct packed {
		logic signed [CW-1:0] point_x;
		logic signed [CW-1:0] point_y;
		logic signed [CW-1:0] point_z;
		logic                 det_positive;
		logic                 singular;
		logic                 saturated;
	} result_word_t;

	typedef struct packed {
		logic [NMAT-1:0][DW-1:0] det;
	} det_word_t;

	typedef struct packed {
		logic [DW-1:0] rem;
		logic [QW-1:0] qn;
		logic          neg;
		logic          ovf;
	} div_lane_t;

	typedef struct packed {
		div_lane_t [2:0] lane;
		logic [DW-1:0]   den;
		logic            singular;
		logic            det_pos;
	} div_word_t;

	// column k of matrix m: matrix 0 is the normals, matrix m swaps column m-1 for d
	function automatic logic [1:0] col_of(input int m, input int k);
		logic [1:0] c;
		c = (m != 0 && k == m - 1) ? 2'd3 : 2'(k);
		return c;
	endfunction

	// minor k of the first-row expansion uses columns (minor_i, minor_j)
	function automatic int minor_i(input int k);
		return (k == 0) ? 1 : 0;
	endfunction

	function automatic int minor_j(input int k);
		return (k == 2) ? 1 : 2;
	endfunction

endpackage

// ===== rtl/core/tpi_det.sv =====
// ----------------------------------------------------------------------------
// tpi_det
// five-stage pipeline for the four 3x3 determinants (system and numerators)
// ----------------------------------------------------------------------------
module tpi_det import tpi_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  plane_word_t in_word,
	output logic        out_valid,
	input  logic        out_ready,
	output det_word_t   out_word
);

	logic signed [CW-1:0] elem [3][4];

	logic signed [PW-1:0]  prod_p_s1 [NMAT][3];
	logic signed [PW-1:0]  prod_q_s1 [NMAT][3];
	logic signed [CW-1:0]  a_s1      [NMAT][3];
	logic signed [MW-1:0]  minor_s2  [NMAT][3];
	logic signed [CW-1:0]  a_s2      [NMAT][3];
	logic signed [PPW-1:0] pl_s3     [NMAT][3];
	logic signed [PPW-1:0] ph_s3     [NMAT][3];
	logic signed [TW-1:0]  term_s4   [NMAT][3];
	logic signed [DW-1:0]  det_s5    [NMAT];

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5;

	assign elem[0][0] = in_word.first_normal_x;
	assign elem[0][1] = in_word.first_normal_y;
	assign elem[0][2] = in_word.first_normal_z;
	assign elem[0][3] = in_word.first_offset;
	assign elem[1][0] = in_word.second_normal_x;
	assign elem[1][1] = in_word.second_normal_y;
	assign elem[1][2] = in_word.second_normal_z;
	assign elem[1][3] = in_word.second_offset;
	assign elem[2][0] = in_word.third_normal_x;
	assign elem[2][1] = in_word.third_normal_y;
	assign elem[2][2] = in_word.third_normal_z;
	assign elem[2][3] = in_word.third_offset;

	// a stage takes a new word when empty or when its contents move on
	assign rdy_s5    = !vld_s5 || out_ready;
	assign rdy_s4    = !vld_s4 || rdy_s5;
	assign rdy_s3    = !vld_s3 || rdy_s4;
	assign rdy_s2    = !vld_s2 || rdy_s3;
	assign rdy_s1    = !vld_s1 || rdy_s2;
	assign in_ready  = rdy_s1;
	assign out_valid = vld_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= in_valid;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
			if (rdy_s4) vld_s4 <= vld_s3;
			if (rdy_s5) vld_s5 <= vld_s4;
		end
	end

	// 2x2 products of the lower two rows
	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			for (int m = 0; m < NMAT; m++) begin
				for (int k = 0; k < 3; k++) begin
					prod_p_s1[m][k] <= PW'(elem[1][col_of(m, minor_i(k))])
						* PW'(elem[2][col_of(m, minor_j(k))]);
					prod_q_s1[m][k] <= PW'(elem[1][col_of(m, minor_j(k))])
						* PW'(elem[2][col_of(m, minor_i(k))]);
					a_s1[m][k] <= elem[0][col_of(m, k)];
				end
			end
		end
	end

	// minors
	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			for (int m = 0; m < NMAT; m++) begin
				for (int k = 0; k < 3; k++) begin
					minor_s2[m][k] <= MW'(prod_p_s1[m][k]) - MW'(prod_q_s1[m][k]);
					a_s2[m][k]     <= a_s1[m][k];
				end
			end
		end
	end

	// first-row element times minor, split into low and high partial products
	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			for (int m = 0; m < NMAT; m++) begin
				for (int k = 0; k < 3; k++) begin
					pl_s3[m][k] <= PPW'(a_s2[m][k])
						* PPW'($signed({1'b0, minor_s2[m][k][LOW-1:0]}));
					ph_s3[m][k] <= PPW'(a_s2[m][k])
						* PPW'($signed(minor_s2[m][k][MW-1:LOW]));
				end
			end
		end
	end

	// recombine partial products
	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			for (int m = 0; m < NMAT; m++) begin
				for (int k = 0; k < 3; k++) begin
					term_s4[m][k] <= (TW'(ph_s3[m][k]) <<< LOW) + TW'(pl_s3[m][k]);
				end
			end
		end
	end

	// cofactor sum
	always_ff @(posedge clk) begin
		if (rdy_s5) begin
			for (int m = 0; m < NMAT; m++) begin
				det_s5[m] <= DW'(term_s4[m][0]) - DW'(term_s4[m][1]) + DW'(term_s4[m][2]);
			end
		end
	end

	always_comb begin
		for (int m = 0; m < NMAT; m++) begin
			out_word.det[m] = det_s5[m];
		end
	end

endmodule

// ===== rtl/core/tpi_prep.sv =====
// ----------------------------------------------------------------------------
// tpi_prep
// sign split, fraction scaling and range check ahead of the dividers
// ----------------------------------------------------------------------------
module tpi_prep import tpi_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  det_word_t in_word,
	output logic      out_valid,
	input  logic      out_ready,
	output div_word_t out_word
);

	logic      vld_s1;
	div_word_t word_s1;
	div_word_t word_d;
	logic [DW-1:0] den_mag;
	logic [DW-1:0] num_mag [3];
	logic [NW-1:0] num_sh  [3];
	logic          den_neg;

	assign in_ready  = !vld_s1 || out_ready;
	assign out_valid = vld_s1;
	assign out_word  = word_s1;

	always_comb begin
		den_neg = in_word.det[0][DW-1];
		den_mag = den_neg ? DW'(-in_word.det[0]) : in_word.det[0];
		word_d.den      = den_mag;
		word_d.singular = (in_word.det[0] == '0);
		word_d.det_pos  = !den_neg && (in_word.det[0] != '0);
		for (int l = 0; l < 3; l++) begin
			num_mag[l] = in_word.det[l+1][DW-1] ? DW'(-in_word.det[l+1]) : in_word.det[l+1];
			num_sh[l]  = {num_mag[l], {FB{1'b0}}};
			word_d.lane[l].neg = in_word.det[l+1][DW-1] ^ den_neg;
			// quotient would not fit in the kept bits
			word_d.lane[l].ovf = DW'(num_sh[l][NW-1:QW]) >= den_mag;
			word_d.lane[l].rem = DW'(num_sh[l][NW-1:QW]);
			word_d.lane[l].qn  = num_sh[l][QW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) word_s1 <= word_d;
	end

endmodule

// ===== rtl/core/tpi_div_step.sv =====
// ----------------------------------------------------------------------------
// tpi_div_step
// one restoring quotient bit for all three coordinate lanes
// ----------------------------------------------------------------------------
module tpi_div_step import tpi_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  div_word_t in_word,
	output logic      out_valid,
	input  logic      out_ready,
	output div_word_t out_word
);

	logic      vld_s1;
	div_word_t word_s1;
	div_word_t word_d;
	logic [DW:0] trial [3];
	logic        ge    [3];

	assign in_ready  = !vld_s1 || out_ready;
	assign out_valid = vld_s1;
	assign out_word  = word_s1;

	always_comb begin
		word_d = in_word;
		for (int l = 0; l < 3; l++) begin
			trial[l] = {in_word.lane[l].rem, in_word.lane[l].qn[QW-1]};
			ge[l]    = trial[l] >= {1'b0, in_word.den};
			word_d.lane[l].rem = ge[l] ? DW'(trial[l] - {1'b0, in_word.den})
			                           : trial[l][DW-1:0];
			word_d.lane[l].qn  = {in_word.lane[l].qn[QW-2:0], ge[l]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) word_s1 <= word_d;
	end

endmodule

// ===== rtl/core/tpi_out.sv =====
// ----------------------------------------------------------------------------
// tpi_out
// saturation, sign restore and result register
// ----------------------------------------------------------------------------
module tpi_out import tpi_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  div_word_t    in_word,
	output logic         out_valid,
	input  logic         out_ready,
	output result_word_t out_word
);

	localparam logic [QW-1:0] POS_LIM = QW'((64'd1 << (CW - 1)) - 64'd1);
	localparam logic [QW-1:0] NEG_LIM = QW'(64'd1 << (CW - 1));

	logic         vld_s1;
	result_word_t word_s1;
	result_word_t word_d;
	logic [CW-1:0] coord [3];
	logic          clip  [3];

	assign in_ready  = !vld_s1 || out_ready;
	assign out_valid = vld_s1;
	assign out_word  = word_s1;

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			clip[l] = in_word.lane[l].ovf
				|| (in_word.lane[l].qn > (in_word.lane[l].neg ? NEG_LIM : POS_LIM));
			if (in_word.singular) begin
				coord[l] = '0;
			end else if (clip[l]) begin
				coord[l] = in_word.lane[l].neg ? NEG_LIM[CW-1:0] : POS_LIM[CW-1:0];
			end else begin
				coord[l] = in_word.lane[l].neg ? CW'(-in_word.lane[l].qn)
				                               : in_word.lane[l].qn[CW-1:0];
			end
		end
		word_d.point_x      = $signed(coord[0]);
		word_d.point_y      = $signed(coord[1]);
		word_d.point_z      = $signed(coord[2]);
		word_d.det_positive = in_word.det_pos;
		word_d.singular     = in_word.singular;
		word_d.saturated    = !in_word.singular && (clip[0] || clip[1] || clip[2]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) word_s1 <= word_d;
	end

endmodule

// ===== rtl/core/three_plane_intersection.sv =====
// ----------------------------------------------------------------------------
// three_plane_intersection
// common point of three planes by Cramer's rule, signed Q16.16, fully pipelined
// ----------------------------------------------------------------------------
// Accepts one word of three planes (normal and offset each) per clock and
// returns one result word per clock while the result side keeps taking them.
// The path runs through five stages for the four exact determinants, one for
// sign split and scaling, 33 stages of restoring division (one quotient bit
// each, all three coordinates side by side), and the saturating result
// register. Each stage holds its word under back-pressure and takes a new one
// as soon as it is empty, so bubbles close up and no word is lost or repeated.
// A zero determinant gives a zero point with the singular flag; a coordinate
// out of range is clipped and flagged as saturated.
module three_plane_intersection import tpi_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         planes_valid,
	output logic         planes_ready,
	input  plane_word_t  planes,
	output logic         result_valid,
	input  logic         result_ready,
	output result_word_t result
);

	// determinant pipeline to prep
	logic      det_valid, det_ready;
	det_word_t det_word;

	// divider chain, entry 0 from prep, entry QW into the output stage
	logic [QW:0] div_valid, div_ready;
	div_word_t   div_word [QW+1];

	tpi_det u_det (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (planes_valid),
		.in_ready  (planes_ready),
		.in_word   (planes),
		.out_valid (det_valid),
		.out_ready (det_ready),
		.out_word  (det_word)
	);

	// magnitudes, quotient signs and the overflow pre-check
	tpi_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (det_valid),
		.in_ready  (det_ready),
		.in_word   (det_word),
		.out_valid (div_valid[0]),
		.out_ready (div_ready[0]),
		.out_word  (div_word[0])
	);

	// one quotient bit per stage, msb first
	for (genvar g = 0; g < QW; g++) begin : g_div
		tpi_div_step u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (div_valid[g]),
			.in_ready  (div_ready[g]),
			.in_word   (div_word[g]),
			.out_valid (div_valid[g+1]),
			.out_ready (div_ready[g+1]),
			.out_word  (div_word[g+1])
		);
	end

	// clip, restore sign, register the result word
	tpi_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (div_valid[QW]),
		.in_ready  (div_ready[QW]),
		.in_word   (div_word[QW]),
		.out_valid (result_valid),
		.out_ready (result_ready),
		.out_word  (result)
	);

`ifndef NO_ASSERTIONS
	// input stalls only when the whole pipe is full behind a waiting result
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!planes_ready |-> (result_valid && !result_ready))
		else $error("input stalled while the output side can drain");

	// singular result carries a zero point and no other flag
	a_singular_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.singular) |->
		(result.point_x == '0 && result.point_y == '0 && result.point_z == '0
		 && !result.det_positive && !result.saturated))
		else $error("singular result with nonzero point or flags");

	// a word that reaches the divider output moves on or is held next cycle
	a_div_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(div_valid[QW] && !div_ready[QW]) |=> div_valid[QW] && $stable(div_word[QW]))
		else $error("divider output dropped or changed under stall");
`endif

endmodule

// ===== sim/tb_three_plane_intersection.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_three_plane_intersection
// self-checking bench for the three-plane Cramer solver
// ----------------------------------------------------------------------------
// Plane triples go in through a queue-fed driver; each accepted word is solved
// at once by an exact wide-integer predictor and the result is queued. The
// monitor compares every result word field by field against the oldest entry.
// Both sides idle at random, with a stretch of no idling and one drain pause.
module tb_three_plane_intersection;
	import tpi_pkg::*;

	localparam int LATENCY = 40;
	localparam int XW      = 200;   // exact intermediate width

	logic         clk;
	logic         arst_n;
	logic         planes_valid;
	logic         planes_ready;
	plane_word_t  planes;
	logic         result_valid;
	logic         result_ready;
	result_word_t result;

	plane_word_t  pending_planes[$];
	result_word_t expected_points[$];
	int           error_count;
	bit           idle_enable;
	bit           hold_sender;

	three_plane_intersection uut (
		.clk(clk), .arst_n(arst_n),
		.planes_valid(planes_valid), .planes_ready(planes_ready), .planes(planes),
		.result_valid(result_valid), .result_ready(result_ready), .result(result)
	);

	// clock, 4 ns period
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// append one plane triple to the driver queue
	function automatic void add_planes(input plane_word_t p);
		pending_planes.insert(pending_planes.size(), p);
	endfunction

	// 3x3 determinant of rows (a, b, c), exact
	function automatic logic signed [XW-1:0] det3(
		input logic signed [XW-1:0] a0, a1, a2, b0, b1, b2, c0, c1, c2);
		logic signed [XW-1:0] m0, m1, m2;
		m0 = b1 * c2 - b2 * c1;
		m1 = b0 * c2 - b2 * c0;
		m2 = b0 * c1 - b1 * c0;
		return a0 * m0 - a1 * m1 + a2 * m2;
	endfunction

	// num * 2^FB / den, truncated toward zero, clipped to the coordinate range
	function automatic logic signed [CW-1:0] scaled_quotient(
		input logic signed [XW-1:0] num, input logic signed [XW-1:0] den,
		inout logic clipped);
		logic [XW-1:0] mag_n, mag_d, quo;
		logic          neg;
		neg   = (num < 0) != (den < 0);
		mag_n = (num < 0) ? -num : num;
		mag_d = (den < 0) ? -den : den;
		quo   = (mag_n << FB) / mag_d;
		if (!neg && quo > XW'((64'd1 << (CW - 1)) - 1)) begin
			clipped = 1'b1;
			return {1'b0, {(CW-1){1'b1}}};
		end
		if (neg && quo > XW'(64'd1 << (CW - 1))) begin
			clipped = 1'b1;
			return {1'b1, {(CW-1){1'b0}}};
		end
		return neg ? -CW'(quo) : CW'(quo);
	endfunction

	function automatic result_word_t solve_planes(input plane_word_t p);
		logic signed [XW-1:0] ax, ay, az, d1, bx, by, bz, d2, cx, cy, cz, d3, den;
		result_word_t r;
		logic         clipped;
		ax = p.first_normal_x;  ay = p.first_normal_y;  az = p.first_normal_z;
		d1 = p.first_offset;
		bx = p.second_normal_x; by = p.second_normal_y; bz = p.second_normal_z;
		d2 = p.second_offset;
		cx = p.third_normal_x;  cy = p.third_normal_y;  cz = p.third_normal_z;
		d3 = p.third_offset;
		r = '0;
		clipped = 1'b0;
		den = det3(ax, ay, az, bx, by, bz, cx, cy, cz);
		if (den == 0) begin
			r.singular = 1'b1;
			return r;
		end
		r.point_x = scaled_quotient(det3(d1, ay, az, d2, by, bz, d3, cy, cz), den, clipped);
		r.point_y = scaled_quotient(det3(ax, d1, az, bx, d2, bz, cx, d3, cz), den, clipped);
		r.point_z = scaled_quotient(det3(ax, ay, d1, bx, by, d2, cx, cy, d3), den, clipped);
		r.det_positive = (den > 0);
		r.saturated = clipped;
		return r;
	endfunction

	// random coordinate: mostly modest values, sometimes extremes or full range
	function automatic logic [CW-1:0] rand_coord();
		case ($urandom_range(0, 9))
			0: return {1'b0, {(CW-1){1'b1}}};
			1: return {1'b1, {(CW-1){1'b0}}};
			2: return '0;
			3, 4: return $urandom;
			5: return CW'($signed($urandom_range(0, 8)) - 4) << FB;
			default: return CW'(int'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000);
		endcase
	endfunction

	function automatic plane_word_t rand_planes();
		plane_word_t p;
		p.first_normal_x  = rand_coord(); p.first_normal_y  = rand_coord();
		p.first_normal_z  = rand_coord(); p.first_offset    = rand_coord();
		p.second_normal_x = rand_coord(); p.second_normal_y = rand_coord();
		p.second_normal_z = rand_coord(); p.second_offset   = rand_coord();
		p.third_normal_x  = rand_coord(); p.third_normal_y  = rand_coord();
		p.third_normal_z  = rand_coord(); p.third_offset    = rand_coord();
		// some triples made singular by repeating a normal
		if ($urandom_range(0, 9) == 0) begin
			p.third_normal_x = p.first_normal_x;
			p.third_normal_y = p.first_normal_y;
			p.third_normal_z = p.first_normal_z;
		end
		return p;
	endfunction

	function automatic plane_word_t axis_planes(input logic signed [CW-1:0] s,
		input logic signed [CW-1:0] dx, dy, dz);
		plane_word_t p;
		p = '0;
		p.first_normal_x = s;  p.first_offset  = dx;
		p.second_normal_y = s; p.second_offset = dy;
		p.third_normal_z = s;  p.third_offset  = dz;
		return p;
	endfunction

	// driver: hold the word until it is taken, then load the next one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			planes_valid <= 1'b0;
			planes <= '0;
		end else if (!planes_valid || planes_ready) begin
			if (pending_planes.size() != 0 && !hold_sender &&
			    !(idle_enable && $urandom_range(0, 99) < 37)) begin
				planes_valid <= 1'b1;
				planes <= pending_planes.pop_front();
			end else begin
				planes_valid <= 1'b0;
			end
		end
	end

	// predictor runs on every accepted word
	always @(posedge clk) begin
		if (arst_n && planes_valid && planes_ready)
			expected_points.insert(expected_points.size(), solve_planes(planes));
	end

	// receiver stalls at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_ready <= 1'b0;
		else
			result_ready <= !(idle_enable && $urandom_range(0, 99) < 37);
	end

	// monitor: compare each result word with the oldest expectation
	always @(posedge clk) begin
		result_word_t want;
		if (arst_n && result_valid && result_ready) begin
			if (expected_points.size() == 0) begin
				$display("%0t: unexpected word %h", $time, result);
				error_count++;
			end else begin
				want = expected_points.pop_front();
				if (result.point_x !== want.point_x) begin
					$display("%0t: point_x expected %h actual %h", $time, want.point_x,
						result.point_x);
					error_count++;
				end
				if (result.point_y !== want.point_y) begin
					$display("%0t: point_y expected %h actual %h", $time, want.point_y,
						result.point_y);
					error_count++;
				end
				if (result.point_z !== want.point_z) begin
					$display("%0t: point_z expected %h actual %h", $time, want.point_z,
						result.point_z);
					error_count++;
				end
				if (result.det_positive !== want.det_positive) begin
					$display("%0t: det_positive expected %b actual %b", $time,
						want.det_positive, result.det_positive);
					error_count++;
				end
				if (result.singular !== want.singular) begin
					$display("%0t: singular expected %b actual %b", $time, want.singular,
						result.singular);
					error_count++;
				end
				if (result.saturated !== want.saturated) begin
					$display("%0t: saturated expected %b actual %b", $time, want.saturated,
						result.saturated);
					error_count++;
				end
			end
		end
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		plane_word_t p;
		int          waited;
		error_count = 0;
		idle_enable = 1'b0;
		hold_sender = 1'b0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: unit axes, negative scale, huge and tiny results, singular
		add_planes(axis_planes(32'sh0001_0000, 32'sh0002_0000,
			-32'sh0003_0000, 32'sh0000_8000));
		add_planes(axis_planes(-32'sh0001_0000, 32'sh0001_0000,
			32'sh0001_0000, 32'sh0001_0000));
		add_planes(axis_planes(32'sh0000_0001, 32'sh7fff_ffff,
			32'sh8000_0000, 32'sh0000_0001));
		add_planes(axis_planes(-32'sh0000_0001, 32'sh7fff_ffff,
			32'sh8000_0000, 32'sh0000_0000));
		add_planes(axis_planes(32'sh7fff_ffff, 32'sh8000_0000,
			32'sh7fff_ffff, 32'sh0000_0001));
		add_planes(axis_planes(32'sh8000_0000, 32'sh8000_0000,
			32'sh7fff_ffff, -32'sh0000_0001));
		add_planes('0);
		add_planes('1);
		p = '0;
		{p.first_normal_x, p.first_normal_y, p.first_normal_z} = {3{32'sh8000_0000}};
		{p.second_normal_x, p.third_normal_y} = {2{32'sh7fff_ffff}};
		p.third_normal_z = 32'sh8000_0000;
		{p.first_offset, p.second_offset, p.third_offset} = {3{32'sh7fff_ffff}};
		add_planes(p);
		p = axis_planes(32'sh0001_0000, 32'sh1, 32'sh2, 32'sh3);
		p.second_normal_x = p.first_normal_x;
		p.second_normal_y = '0;
		p.second_normal_z = '0;
		add_planes(p);
		for (int i = 0; i < 10; i++)
			add_planes(rand_planes());

		// random part without idling, then with idling
		for (int i = 0; i < 250; i++)
			add_planes(rand_planes());
		wait (pending_planes.size() == 0);
		idle_enable = 1'b1;

		// sender holds off until the pipeline drains
		hold_sender = 1'b1;
		wait (!planes_valid && expected_points.size() == 0);
		repeat (5) @(posedge clk);
		hold_sender = 1'b0;
		for (int i = 0; i < 580; i++)
			add_planes(rand_planes());
		wait (pending_planes.size() == 0);
		@(posedge clk);
		wait (!planes_valid);

		waited = 0;
		while (expected_points.size() != 0 && waited < 100_000) begin
			@(posedge clk);
			waited++;
		end
		repeat (2 * LATENCY) @(posedge clk);
		if (error_count == 0 && expected_points.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/tpi_pkg.sv
rtl/core/tpi_det.sv
rtl/core/tpi_prep.sv
rtl/core/tpi_div_step.sv
rtl/core/tpi_out.sv
rtl/core/three_plane_intersection.sv
sim/tb_three_plane_intersection.sv
